// ----- rtl/bpu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int MAX_WIDTH       = 4096;
  localparam int MAX_HEIGHT      = 4096;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Pixel formats.
  localparam logic [2:0] FMT_IDX1   = 3'd0;
  localparam logic [2:0] FMT_IDX2   = 3'd1;
  localparam logic [2:0] FMT_IDX4   = 3'd2;
  localparam logic [2:0] FMT_IDX8   = 3'd3;
  localparam logic [2:0] FMT_RGBA8  = 3'd4;
  localparam logic [2:0] FMT_RGBA16 = 3'd5;
  localparam logic [2:0] FMT_RGB24  = 3'd6;
  localparam logic [2:0] FMT_RGBA32 = 3'd7;

  localparam logic [2:0]  FMT_RESET    = FMT_RGBA32;
  localparam logic [12:0] WIDTH_RESET  = 13'd1;
  localparam logic [12:0] HEIGHT_RESET = 13'd1;

  // Job codes passed from the front end to the back end.
  localparam logic [1:0] OP_PAL  = 2'd0;
  localparam logic [1:0] OP_IDX  = 2'd1;
  localparam logic [1:0] OP_WORD = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [1:0]           depth;     // log2 of bits per index field
    logic [3:0]           count;     // pixels in this job
    logic                 eor_last;  // last pixel of the job ends a row
    logic                 eoi_last;  // last pixel of the job ends the image
    logic [PAL_IDX_W-1:0] pal_index;
    logic [31:0]          data;      // byte, finished pixel or palette word
  } job_t;

  // Bytes per row including padding to a four byte boundary.
  function automatic logic [14:0] calc_row_bytes(input logic [2:0] fmt,
                                                 input logic [12:0] w);
    logic [17:0] bits;
    logic [17:0] rounded;
    begin
      case (fmt)
        FMT_IDX1:   bits = {5'd0, w};
        FMT_IDX2:   bits = {4'd0, w, 1'b0};
        FMT_IDX4:   bits = {3'd0, w, 2'b0};
        FMT_IDX8,
        FMT_RGBA8:  bits = {2'd0, w, 3'b0};
        FMT_RGBA16: bits = {1'd0, w, 4'b0};
        FMT_RGB24:  bits = {1'd0, w, 4'b0} + {2'd0, w, 3'b0};
        default:    bits = {w, 5'b0};
      endcase
      rounded = bits + 18'd31;
      calc_row_bytes = {rounded[17:5], 2'b00};
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bpu_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bpu_queue
  import bpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head_job,
  output logic      empty
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bpu_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_front
// Accepts items, keeps the row position and gathers multi-byte pixels.
// ----------------------------------------------------------------------------
module bpu_front
  import bpu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  palette_index,
  input  wire logic [31:0] palette_word,
  input  wire logic        q_full,
  output logic             push,
  output job_t             push_job
);

  logic [2:0]  pixel_format;
  logic [12:0] image_width;
  logic [12:0] image_height;

  // Derived limits, clamped and computed combinationally from the registers.
  logic [12:0] width_eff;
  logic [12:0] height_eff;
  logic [14:0] row_bytes;
  logic [12:0] width_clamp;
  logic [12:0] height_clamp;

  logic [14:0] byte_in_row;
  logic [12:0] pixel_in_row;
  logic [11:0] row_number;
  logic [23:0] partial_pixel;
  logic [1:0]  partial_count;

  logic        accept;
  logic        in_row;
  logic [12:0] avail;
  logic [3:0]  per_byte;
  logic [3:0]  n_pix;
  logic        eor;
  logic        last_row;
  logic        complete;
  logic [31:0] raw;
  logic [31:0] word;
  logic [15:0] byte_next;
  logic [23:0] partial_pixel_next;
  logic [1:0]  partial_count_next;

  assign width_clamp  = (image_width == '0) ? 13'd1 :
                        (image_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : image_width;
  assign height_clamp = (image_height == '0) ? 13'd1 :
                        (image_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : image_height;

  assign width_eff  = width_clamp;
  assign height_eff = height_clamp;
  assign row_bytes  = calc_row_bytes(pixel_format, width_clamp);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FORMAT: pixel_format <= cfg_data[2:0];
          REG_WIDTH:  image_width  <= cfg_data;
          REG_HEIGHT: image_height <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign in_row   = (pixel_in_row < width_eff);
  assign avail    = width_eff - pixel_in_row;
  assign per_byte = 4'd8 >> pixel_format[1:0];
  assign last_row = ({1'b0, row_number} + 13'd1 == height_eff);

  // A packed pixel is complete once its last byte arrives.
  assign complete = (partial_count >= pixel_format[1:0]);
  assign raw      = {8'd0, partial_pixel} | ({24'd0, data_byte} << {partial_count, 3'b000});

  always_comb begin
    case (pixel_format)
      FMT_RGBA8: begin
        word = {8'(raw[7:6] * 8'd85), 8'(raw[5:4] * 8'd85),
                8'(raw[3:2] * 8'd85), 8'(raw[1:0] * 8'd85)};
      end
      FMT_RGBA16: begin
        word = {8'(raw[15:12] * 8'd17), 8'(raw[11:8] * 8'd17),
                8'(raw[7:4] * 8'd17), 8'(raw[3:0] * 8'd17)};
      end
      FMT_RGB24: word = {8'hFF, raw[23:0]};
      default:   word = raw;
    endcase
  end

  always_comb begin
    n_pix              = 4'd0;
    eor                = 1'b0;
    partial_pixel_next = partial_pixel;
    partial_count_next = partial_count;
    if (!pixel_format[2]) begin
      partial_pixel_next = '0;
      partial_count_next = '0;
      if (in_row) begin
        n_pix = (avail < {9'd0, per_byte}) ? avail[3:0] : per_byte;
        eor   = (avail <= {9'd0, per_byte});
      end
    end else if (in_row) begin
      if (complete) begin
        n_pix              = 4'd1;
        eor                = (avail == 13'd1);
        partial_pixel_next = '0;
        partial_count_next = '0;
      end else begin
        partial_pixel_next = raw[23:0];
        partial_count_next = partial_count + 2'd1;
      end
    end
  end

  assign byte_next = {1'b0, byte_in_row} + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row   <= '0;
      pixel_in_row  <= '0;
      row_number    <= '0;
      partial_pixel <= '0;
      partial_count <= '0;
    end else if (accept && !kind) begin
      if (byte_next >= {1'b0, row_bytes}) begin
        byte_in_row   <= '0;
        pixel_in_row  <= '0;
        partial_pixel <= '0;
        partial_count <= '0;
        row_number    <= last_row || ({1'b0, row_number} + 13'd1 > height_eff) ?
                         12'd0 : row_number + 12'd1;
      end else begin
        byte_in_row   <= byte_next[14:0];
        pixel_in_row  <= pixel_in_row + {9'd0, n_pix};
        partial_pixel <= partial_pixel_next;
        partial_count <= partial_count_next;
      end
    end
  end

  // Bytes that produce no pixel never enter the queue.
  assign push = accept && (kind || (n_pix != 4'd0));

  always_comb begin
    push_job.op        = kind ? OP_PAL : (pixel_format[2] ? OP_WORD : OP_IDX);
    push_job.depth     = pixel_format[1:0];
    push_job.count     = n_pix;
    push_job.eor_last  = eor;
    push_job.eoi_last  = eor && last_row;
    push_job.pal_index = palette_index;
    push_job.data      = kind ? palette_word : (pixel_format[2] ? word : {24'd0, data_byte});
  end

endmodule
`default_nettype wire

// ----- rtl/bpu_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_back
// Runs queued jobs: palette writes, index lookups and pixel output.
// ----------------------------------------------------------------------------
module bpu_back
  import bpu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  head_job,
  input  wire logic  q_empty,
  output logic       pop,
  input  wire logic  out_stall,
  output logic       out_valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic       end_of_row,
  output logic       end_of_image
);

  logic [31:0] palette_table [PALETTE_ENTRIES];
  logic [31:0] rdata;

  logic [2:0]  k;
  logic        last;
  logic        pal_fire;
  logic        pix_fire;
  logic        p1_valid;
  logic        p1_indexed;
  logic [31:0] p1_word;
  logic        p1_eor;
  logic        p1_eoi;
  logic        p1_free;
  logic        out_load;
  logic [2:0]  shamt;
  logic [7:0]  shifted;
  logic [7:0]  field;
  logic [31:0] pixel;

  assign out_load = p1_valid && (!out_valid || !out_stall);
  assign p1_free  = !p1_valid || out_load;

  assign last     = ({1'b0, k} + 4'd1 == head_job.count);
  assign pal_fire = !q_empty && (head_job.op == OP_PAL);
  assign pix_fire = !q_empty && (head_job.op != OP_PAL) && p1_free;
  assign pop      = pal_fire || (pix_fire && last);

  // Index fields are taken most significant first.
  assign shamt   = k << head_job.depth;
  assign shifted = head_job.data[7:0] << shamt;

  always_comb begin
    case (head_job.depth)
      2'd0:    field = {7'd0, shifted[7]};
      2'd1:    field = {6'd0, shifted[7:6]};
      2'd2:    field = {4'd0, shifted[7:4]};
      default: field = shifted;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (pix_fire) begin
      k <= last ? 3'd0 : k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_fire) begin
      palette_table[head_job.pal_index] <= head_job.data;
    end
    if (pix_fire) begin
      rdata <= palette_table[field[PAL_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_free) begin
      p1_valid <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      p1_indexed <= (head_job.op == OP_IDX);
      p1_word    <= head_job.data;
      p1_eor     <= last && head_job.eor_last;
      p1_eoi     <= last && head_job.eoi_last;
    end
  end

  assign pixel = p1_indexed ? rdata : p1_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red          <= pixel[7:0];
      green        <= pixel[15:8];
      blue         <= pixel[23:16];
      alpha        <= pixel[31:24];
      end_of_row   <= p1_eor;
      end_of_image <= p1_eoi;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bitmap_pixel_unpacker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_pixel_unpacker
// Turns raw bitmap pixel bytes and palette writes into RGBA pixel items.
// ----------------------------------------------------------------------------
//   channel  handshake              payload
//   in       in_valid / in_stall    kind, data_byte, palette_index, palette_word
//   out      out_valid / out_stall  red, green, blue, alpha, end_of_row,
//                                   end_of_image
//   cfg      cfg_write              cfg_index, cfg_data
//
// The front end takes one item per cycle while the job queue has room.
// The back end emits one pixel per cycle while it has pixel jobs, and holds while out_stall is high:
// a packed-format byte yields at most one pixel, an indexed byte up to eight
// at one bit per pixel, each read through the single palette read port.
// A byte passes through a queue slot, the p1 stage with the palette read and
// the output registers before its first pixel is on the output.
// Reset clears the row counters and the queue and sets rgba32, 1 x 1; the
// palette is undefined until written. A write applies to the next item.
// ----------------------------------------------------------------------------
module bitmap_pixel_unpacker
  import bpu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  palette_index,
  input  wire logic [31:0] palette_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             end_of_row,
  output logic             end_of_image
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  bpu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_word  (palette_word),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  bpu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  bpu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .end_of_row   (end_of_row),
    .end_of_image (end_of_image)
  );

endmodule
`default_nettype wire
